### rtl/core/rpip_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rpip_pkg: types and constants for the radix prefix integer parser
// Item structs for both channels, the character class bundle and ASCII codes.
// ----------------------------------------------------------------------------
package rpip_pkg;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] value;
        logic [15:0]        consumed_len;
        logic               len_overflow;
    } t_out_item;

    typedef struct packed {
        logic       is_space;
        logic       is_sign;
        logic       is_minus;
        logic       is_zero;
        logic       is_dec;
        logic       is_hex;
        logic       is_bin;
        logic       is_x;
        logic       is_b;
        logic [3:0] digit;
    } t_char_class;

    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_0     = 8'd48;
    localparam logic [7:0] CH_1     = 8'd49;
    localparam logic [7:0] CH_9     = 8'd57;
    localparam logic [7:0] CH_UA    = 8'd65;
    localparam logic [7:0] CH_UF    = 8'd70;
    localparam logic [7:0] CH_LA    = 8'd97;
    localparam logic [7:0] CH_LF    = 8'd102;
    localparam logic [7:0] CH_UX    = 8'd88;
    localparam logic [7:0] CH_LX    = 8'd120;
    localparam logic [7:0] CH_UB    = 8'd66;
    localparam logic [7:0] CH_LB    = 8'd98;

endpackage
`default_nettype wire

### rtl/core/rpip_char_class.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rpip_char_class: character classifier
// Decodes one byte into whitespace, sign, prefix letter and digit classes,
// plus its hex digit value.
// ----------------------------------------------------------------------------
module rpip_char_class (
    input  wire logic [7:0]            i_char,
    output rpip_pkg::t_char_class      o_class
);
    import rpip_pkg::*;

    logic       w_is_dec;
    logic       w_is_uhex;
    logic       w_is_lhex;
    logic [3:0] w_digit;

    always_comb begin
        w_is_dec  = (i_char >= CH_0) && (i_char <= CH_9);
        w_is_uhex = (i_char >= CH_UA) && (i_char <= CH_UF);
        w_is_lhex = (i_char >= CH_LA) && (i_char <= CH_LF);

        // hex letters map to 10..15, everything else to its offset from '0' (4 bits)
        if (w_is_uhex) begin
            w_digit = 4'(i_char - CH_UA + 8'd10);
        end else if (w_is_lhex) begin
            w_digit = 4'(i_char - CH_LA + 8'd10);
        end else begin
            w_digit = 4'(i_char - CH_0);
        end

        o_class.is_space = (i_char == CH_SPACE) || ((i_char >= CH_TAB) && (i_char <= CH_CR));
        o_class.is_sign  = (i_char == CH_PLUS) || (i_char == CH_MINUS);
        o_class.is_minus = (i_char == CH_MINUS);
        o_class.is_zero  = (i_char == CH_0);
        o_class.is_dec   = w_is_dec;
        o_class.is_hex   = w_is_dec || w_is_uhex || w_is_lhex;
        o_class.is_bin   = (i_char == CH_0) || (i_char == CH_1);
        o_class.is_x     = (i_char == CH_LX) || (i_char == CH_UX);
        o_class.is_b     = (i_char == CH_LB) || (i_char == CH_UB);
        o_class.digit    = w_digit;
    end

endmodule
`default_nettype wire

### rtl/core/radix_prefix_int_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// radix_prefix_int_parser: streaming integer parser with radix prefix
// Parses one character per item; emits value and length on the last one.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in) carries one character per
//   item, last_char set on the final character of a string. The output
//   channel (o_out_valid / i_out_stall / o_out) carries one result per string.
//   Each character is folded into the running state in the cycle it is
//   accepted, so one item is taken every cycle unless a last character is
//   stalled. The result of a string appears on o_out in the cycle after its
//   last character is accepted. The multiply-add (shift and add) on the
//   accumulator is combinational.
//   When the receiver stalls, the result is held in the output register and
//   characters keep flowing in; only a last character is stalled until the
//   held result is taken.
//   Reset (i_rst_n low, synchronous) returns the parser to whitespace
//   skipping with a cleared accumulator and position, and drops any pending
//   result.
// ----------------------------------------------------------------------------
module radix_prefix_int_parser #(
    parameter int VALUE_BITS = 32,
    parameter int LEN_BITS   = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire rpip_pkg::t_in_item i_in,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output rpip_pkg::t_out_item     o_out
);
    import rpip_pkg::*;

    localparam logic [2:0] PH_SPACE  = 3'd0;
    localparam logic [2:0] PH_SIGNED = 3'd1;
    localparam logic [2:0] PH_ZERO   = 3'd2;
    localparam logic [2:0] PH_DEC    = 3'd3;
    localparam logic [2:0] PH_HEX    = 3'd4;
    localparam logic [2:0] PH_BIN    = 3'd5;
    localparam logic [2:0] PH_DONE   = 3'd6;

    localparam logic [LEN_BITS-1:0] LenMax = '1;

    logic [2:0]            r_phase, n_phase;
    logic                  r_neg, n_neg;
    logic [VALUE_BITS-1:0] r_acc, n_acc;
    logic [LEN_BITS-1:0]   r_pos, n_pos;
    logic [LEN_BITS-1:0]   r_end, n_end;
    logic                  r_sat, n_sat;
    logic                  r_out_valid;
    t_out_item             r_out;

    t_char_class           w_cls;
    logic                  w_in_acc;
    logic [VALUE_BITS-1:0] w_dig;
    logic [VALUE_BITS-1:0] w_acc_dec;
    logic [VALUE_BITS-1:0] w_acc_hex;
    logic [VALUE_BITS-1:0] w_acc_bin;
    logic [VALUE_BITS-1:0] w_val;

    rpip_char_class u_class (
        .i_char  (i_in.char_code),
        .o_class (w_cls)
    );

    // a last character waits only while a result is still held
    assign o_in_stall = r_out_valid && i_out_stall && i_in.last_char;
    assign w_in_acc   = i_in_valid && !o_in_stall;

    assign w_dig     = VALUE_BITS'(w_cls.digit);
    assign w_acc_dec = (r_acc << 3) + (r_acc << 1) + w_dig;
    assign w_acc_hex = (r_acc << 4) + w_dig;
    assign w_acc_bin = (r_acc << 1) + w_dig;

    always_comb begin
        n_phase = r_phase;
        n_neg   = r_neg;
        n_acc   = r_acc;
        n_end   = r_end;
        n_sat   = r_sat;
        n_pos   = r_pos;

        if (r_pos == LenMax) begin
            n_sat = 1'b1;
        end else begin
            n_pos = r_pos + LEN_BITS'(1);
        end

        unique case (r_phase) inside
            PH_SPACE, PH_SIGNED: begin
                if (r_phase == PH_SPACE && w_cls.is_space) begin
                    n_phase = r_phase;
                end else if (r_phase == PH_SPACE && w_cls.is_sign) begin
                    n_neg   = w_cls.is_minus;
                    n_phase = PH_SIGNED;
                end else if (w_cls.is_zero) begin
                    n_acc   = w_acc_dec;
                    n_end   = n_pos;
                    n_phase = PH_ZERO;
                end else if (w_cls.is_dec) begin
                    n_acc   = w_acc_dec;
                    n_end   = n_pos;
                    n_phase = PH_DEC;
                end else begin
                    n_phase = PH_DONE;
                end
            end
            PH_ZERO: begin
                if (w_cls.is_x) begin
                    n_end   = '0;
                    n_phase = PH_HEX;
                end else if (w_cls.is_b) begin
                    n_end   = '0;
                    n_phase = PH_BIN;
                end else if (w_cls.is_dec) begin
                    n_acc   = w_acc_dec;
                    n_end   = n_pos;
                    n_phase = PH_DEC;
                end else begin
                    n_phase = PH_DONE;
                end
            end
            PH_DEC: begin
                if (w_cls.is_dec) begin
                    n_acc = w_acc_dec;
                    n_end = n_pos;
                end else begin
                    n_phase = PH_DONE;
                end
            end
            PH_HEX: begin
                if (w_cls.is_hex) begin
                    n_acc = w_acc_hex;
                    n_end = n_pos;
                end else begin
                    n_phase = PH_DONE;
                end
            end
            PH_BIN: begin
                if (w_cls.is_bin) begin
                    n_acc = w_acc_bin;
                    n_end = n_pos;
                end else begin
                    n_phase = PH_DONE;
                end
            end
            default: begin
                n_phase = PH_DONE;
            end
        endcase
    end

    assign w_val = n_neg ? (~n_acc + VALUE_BITS'(1)) : n_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SPACE;
            r_neg       <= 1'b0;
            r_acc       <= '0;
            r_pos       <= '0;
            r_end       <= '0;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_acc) begin
                if (i_in.last_char) begin
                    r_phase <= PH_SPACE;
                    r_neg   <= 1'b0;
                    r_acc   <= '0;
                    r_pos   <= '0;
                    r_end   <= '0;
                    r_sat   <= 1'b0;
                end else begin
                    r_phase <= n_phase;
                    r_neg   <= n_neg;
                    r_acc   <= n_acc;
                    r_pos   <= n_pos;
                    r_end   <= n_end;
                    r_sat   <= n_sat;
                end
            end
            if (w_in_acc && i_in.last_char) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && i_in.last_char) begin
            r_out.value        <= 32'(w_val);
            r_out.consumed_len <= 16'(n_end);
            r_out.len_overflow <= n_sat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef SYNTH
    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall && i_in.last_char))
        else $error("result appeared without a last item");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_in.last_char) |=>
            (r_phase == PH_SPACE && r_pos == '0 && r_end == '0 && !r_sat && r_acc == '0))
        else $error("parser state not cleared after last item");

    a_sat_at_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sat |-> (r_pos == LenMax))
        else $error("saturation flag set below max position");

    a_end_le_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_end <= r_pos)
        else $error("end position beyond current position");
`endif

endmodule
`default_nettype wire
